// ===== rtl/core/rad_pkg.sv =====
`default_nettype none
package rad_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] CFG_SRC_W = 3'd0;
    localparam logic [2:0] CFG_SRC_H = 3'd1;
    localparam logic [2:0] CFG_DST_W = 3'd2;
    localparam logic [2:0] CFG_DST_H = 3'd3;
    localparam logic [2:0] CFG_ALPHA = 3'd4;

    localparam int WEIGHT_BITS = 14;   // Q14 weights, one span sums to 1 << 14
    localparam int SPAN_W      = 22;   // horizontal span accumulator
    localparam int HVAL_W      = 16;   // horizontal result after rounding
    localparam int WGT_W       = 15;   // weight, up to 16384
    localparam int NUM_W       = 31;   // quantizer dividend
    localparam int DEN_W       = 16;   // quantizer divisor (a source size)

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_OV    = 8'b0000_1000,
        S_DLD   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_SPAN  = 8'b0100_0000,
        S_WB    = 8'b1000_0000
    } t_state;

    // quantizer jobs: vertical span, vertical carry, horizontal span, horizontal carry
    typedef enum logic [1:0] {
        J_V1 = 2'd0,
        J_V2 = 2'd1,
        J_H1 = 2'd2,
        J_H2 = 2'd3
    } t_job;

    // (c * a + 127) / 255, exact for 16-bit numerators
    function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
        logic [15:0] x;
        logic [16:0] y;
        x = 16'(16'(c) * 16'(a)) + 16'd127;
        y = 17'(x) + 17'(x >> 8) + 17'd1;
        return y[15:8];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rgba_area_downscaler.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_stall         i_pixel[31:0]
// output    out        o_valid / i_stall         o_red o_green o_blue o_alpha o_row_end o_frame_end
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index[2:0] i_cfg_data[15:0]
//
// One pixel is done before the next transfer is taken: it runs J = 1..4 quantizer
// divisions on the one shared 15-step divider, plus a line step when it closes a
// horizontal span.
// Reset (i_rst_n low, synchronous) and every config write to a known index start a
// clearing pass over all MAX_WIDTH entries of the line-sum memory; no pixel is taken during it.
// A finished pixel waits in the output register; the write-back stalls only if a new
// result is ready while the previous one is still held by i_stall.
`default_nettype none
module rgba_area_downscaler
    import rad_pkg::*;
#(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 32768,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_pixel,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic             o_row_end,
    output logic             o_frame_end,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int HSH  = WEIGHT_BITS - FRACTION_BITS;
    localparam int VSH  = WEIGHT_BITS + FRACTION_BITS;
    localparam int LW   = VSH + 8;            // line sum bits that reach the output
    localparam int XW   = CW + 14;            // horizontal positions
    localparam int YW   = RW + 17;            // vertical positions
    localparam int DSTEPS = WGT_W;            // quotient bits

    // configuration
    logic [12:0] r_sw, r_dw;
    logic [15:0] r_sh, r_dh;
    logic        r_alpha_straight;

    // stream state
    logic [SPAN_W-1:0] r_span [4];
    logic [12:0]       r_h_cov;
    logic [WGT_W-1:0]  r_h_total;
    logic [15:0]       r_v_cov;
    logic [WGT_W-1:0]  r_v_total, r_v_now, r_v_next;
    logic [CW-1:0]     r_src_col, r_dst_col;
    logic [RW-1:0]     r_src_row, r_dst_row;

    // per-pixel work registers
    t_state            r_state, n_state;
    t_job              r_job;
    logic [31:0]       r_pix;
    logic [7:0]        r_ch [4];
    logic [YW-1:0]     r_ystart, r_rstart;
    logic [XW-1:0]     r_xstart, r_pstart;
    logic              r_vclose, r_vover, r_hclose, r_hover;
    logic [15:0]       r_vcov_new, r_vov2;
    logic [12:0]       r_hcov_new, r_hov2;
    logic [WGT_W-1:0]  r_qv1, r_qv2, r_qh1, r_qh2;
    logic [LW-1:0]     r_acc [4];
    logic [LW-1:0]     r_hn [4];
    logic [CW-1:0]     r_clr_addr;

    // shared quantizer divider
    logic [DEN_W-1:0]  r_div_rem, r_div_den;
    logic [DSTEPS-1:0] r_div_low, r_div_q;
    logic [3:0]        r_div_cnt;

    // line-sum memory, one row of four channels per destination column
    logic [4*LW-1:0]   r_mem [MAX_WIDTH];
    logic [4*LW-1:0]   r_mem_q;

    // output register
    logic              r_o_valid;
    logic [7:0]        r_o_ch [4];
    logic              r_o_row_end, r_o_frame_end;

    logic cfg_hit, cfg_ok, in_xfer, wb_go;

    assign o_cfg_ready = 1'b1;
    assign cfg_hit = i_cfg_valid && (i_cfg_index == CFG_SRC_W || i_cfg_index == CFG_SRC_H ||
                     i_cfg_index == CFG_DST_W || i_cfg_index == CFG_DST_H ||
                     i_cfg_index == CFG_ALPHA);

    assign cfg_ok = r_sw != '0 && r_sh != '0 && r_dw != '0 && r_dh != '0 &&
                    17'(r_sw) <= 17'(MAX_WIDTH) && 17'(r_sh) <= 17'(MAX_HEIGHT) &&
                    r_dw <= r_sw && r_dh <= r_sh;

    assign o_stall = (r_state != S_IDLE);
    assign in_xfer = i_valid && !o_stall;

    // ---------------- span geometry (from S_MUL products) ----------------
    logic [YW-1:0] yend, rend, vmin, vmax;
    logic [XW-1:0] xend, pend, hmin, hmax;
    always_comb begin
        yend = r_ystart + YW'(r_sh);
        rend = r_rstart + YW'(r_dh);
        vmin = (rend < yend) ? rend : yend;
        vmax = (r_rstart > r_ystart) ? r_rstart : r_ystart;
        xend = r_xstart + XW'(r_sw);
        pend = r_pstart + XW'(r_dw);
        hmin = (pend < xend) ? pend : xend;
        hmax = (r_pstart > r_xstart) ? r_pstart : r_xstart;
    end

    // ---------------- divider ----------------
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [DEN_W:0]   div_t;
    logic             div_ge;
    logic [WGT_W-1:0] div_res;
    always_comb begin
        case (r_job)
            J_V1:    div_num = NUM_W'({r_vcov_new, 14'b0}) + NUM_W'(r_sh >> 1);
            J_V2:    div_num = NUM_W'({r_vov2, 14'b0}) + NUM_W'(r_sh >> 1);
            J_H1:    div_num = NUM_W'({r_hcov_new, 14'b0}) + NUM_W'(r_sw >> 1);
            default: div_num = NUM_W'({r_hov2, 14'b0}) + NUM_W'(r_sw >> 1);
        endcase
        div_den = (r_job == J_V1 || r_job == J_V2) ? r_sh : DEN_W'(r_sw);
        div_t   = {r_div_rem, r_div_low[DSTEPS-1]};
        div_ge  = div_t >= {1'b0, r_div_den};
        div_res = {r_div_q[DSTEPS-2:0], div_ge};
    end

    // ---------------- S_SPAN / S_WB datapath (span, line step, write-back) ----------------
    logic [WGT_W-1:0]  h_w;
    logic [SPAN_W:0]   h_rnd [4];
    logic [HVAL_W-1:0] h_val [4];
    logic [LW-1:0]     mem_ch [4];
    logic [LW-1:0]     o_rnd [4];
    logic [4*LW-1:0]   wb_row;
    logic              line_step;
    assign h_w = r_qh1 - r_h_total;
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            h_rnd[c]  = (SPAN_W+1)'(r_span[c]) + (SPAN_W+1)'(1 << (HSH - 1));
            h_val[c]  = HVAL_W'(h_rnd[c] >> HSH);
            mem_ch[c] = r_mem_q[c*LW +: LW];
            o_rnd[c]  = r_acc[c] + LW'(1 << (VSH - 1));
            wb_row[c*LW +: LW] = r_vclose ? r_hn[c] : r_acc[c];
        end
    end

    // S_SPAN is followed by one line step (memory add) when the pixel closes a column
    logic r_line_done;
    assign line_step = r_hclose && !r_line_done;
    assign wb_go = !(r_hclose && r_vclose && r_o_valid && i_stall);

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_addr == CW'(MAX_WIDTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (in_xfer && cfg_ok) n_state = S_MUL;
            S_MUL:   n_state = S_OV;
            S_OV:    n_state = S_DLD;
            S_DLD:   n_state = S_DIV;
            S_DIV: begin
                if (r_div_cnt == 4'(DSTEPS - 1)) begin
                    unique case (r_job)
                        J_V1:    n_state = S_DLD;
                        J_V2:    n_state = S_DLD;
                        J_H1:    n_state = r_hover ? S_DLD : S_SPAN;
                        J_H2:    n_state = S_SPAN;
                        default: n_state = S_SPAN;
                    endcase
                end
            end
            S_SPAN:  n_state = S_WB;
            S_WB:    if (!line_step && wb_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (cfg_hit) n_state = S_CLEAR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_hit || r_state != S_CLEAR) r_clr_addr <= '0;
            else r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= 13'd1;
            r_sh <= 16'd1;
            r_dw <= 13'd1;
            r_dh <= 16'd1;
            r_alpha_straight <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SRC_W: r_sw <= i_cfg_data[12:0];
                CFG_SRC_H: r_sh <= i_cfg_data;
                CFG_DST_W: r_dw <= i_cfg_data[12:0];
                CFG_DST_H: r_dh <= i_cfg_data;
                CFG_ALPHA: r_alpha_straight <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // line memory: clearing pass or write-back, read every cycle at the current column
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_mem[r_clr_addr] <= '0;
        end else if (r_state == S_WB && !line_step && wb_go && r_hclose) begin
            r_mem[r_dst_col] <= wb_row;
        end
        r_mem_q <= r_mem[r_dst_col];
    end

    // per-pixel work registers (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (in_xfer) r_pix <= i_pixel;
        if (r_state == S_MUL) begin
            r_ystart <= YW'(r_dst_row) * YW'(r_sh);
            r_rstart <= YW'(r_src_row) * YW'(r_dh);
            r_xstart <= XW'(r_dst_col) * XW'(r_sw);
            r_pstart <= XW'(r_src_col) * XW'(r_dw);
            for (int c = 0; c < 3; c++)
                r_ch[c] <= r_alpha_straight ? premul(r_pix[8*c +: 8], r_pix[31:24])
                                            : r_pix[8*c +: 8];
            r_ch[3] <= r_pix[31:24];
        end
        if (r_state == S_OV) begin
            r_vclose   <= rend >= yend;
            r_vover    <= rend > yend;
            r_vcov_new <= r_v_cov + 16'(vmin - vmax);
            r_vov2     <= 16'(rend - yend);
            r_hclose   <= pend >= xend;
            r_hover    <= pend > xend;
            r_hcov_new <= r_h_cov + 13'(hmin - hmax);
            r_hov2     <= 13'(pend - xend);
            r_job      <= (r_src_col == '0) ? J_V1 : J_H1;
        end
        if (r_state == S_DLD) begin
            r_div_rem <= div_num[NUM_W-1:DSTEPS];
            r_div_low <= div_num[DSTEPS-1:0];
            r_div_den <= div_den;
            r_div_q   <= '0;
            r_div_cnt <= '0;
        end
        if (r_state == S_DIV) begin
            r_div_rem <= div_ge ? DEN_W'(div_t - {1'b0, r_div_den}) : div_t[DEN_W-1:0];
            r_div_low <= r_div_low << 1;
            r_div_q   <= div_res;
            r_div_cnt <= r_div_cnt + 1'b1;
            if (r_div_cnt == 4'(DSTEPS - 1)) begin
                unique case (r_job)
                    J_V1: begin
                        r_qv1 <= div_res;
                        r_job <= r_vover ? J_V2 : J_H1;
                    end
                    J_V2: begin
                        r_qv2 <= div_res;
                        r_job <= J_H1;
                    end
                    J_H1: begin
                        r_qh1 <= div_res;
                        r_job <= J_H2;
                    end
                    J_H2: r_qh2 <= div_res;
                    default: ;
                endcase
            end
        end
        if (r_state == S_SPAN) r_line_done <= 1'b0;
        if (r_state == S_WB && line_step) begin
            // add this row's share; keep the next row's share for a closing row
            for (int c = 0; c < 4; c++) begin
                r_acc[c] <= mem_ch[c] + LW'(32'(h_val[c]) * 32'(r_v_now));
                r_hn[c]  <= LW'(32'(h_val[c]) * 32'(r_v_next));
            end
            r_line_done <= 1'b1;
        end
    end

    // stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            for (int c = 0; c < 4; c++) r_span[c] <= '0;
            r_h_cov   <= '0;
            r_h_total <= '0;
            r_v_cov   <= '0;
            r_v_total <= '0;
            r_v_now   <= '0;
            r_v_next  <= '0;
            r_src_col <= '0;
            r_dst_col <= '0;
            r_src_row <= '0;
            r_dst_row <= '0;
        end else if (r_state == S_SPAN) begin
            if (r_src_col == '0) begin
                r_v_now <= r_qv1 - r_v_total;
                if (r_vover) begin
                    r_v_next  <= r_qv2;
                    r_v_cov   <= r_vov2;
                    r_v_total <= r_qv2;
                end else if (r_vclose) begin
                    r_v_next  <= '0;
                    r_v_cov   <= '0;
                    r_v_total <= '0;
                end else begin
                    r_v_next  <= '0;
                    r_v_cov   <= r_vcov_new;
                    r_v_total <= r_qv1;
                end
            end
            r_h_cov   <= r_hcov_new;
            r_h_total <= r_qh1;
            for (int c = 0; c < 4; c++)
                r_span[c] <= r_span[c] + SPAN_W'(23'(r_ch[c]) * 23'(h_w));
        end else if (r_state == S_WB && !line_step && wb_go) begin
            if (32'(r_src_col) + 32'd1 >= 32'(r_sw)) begin
                // end of source row
                for (int c = 0; c < 4; c++) r_span[c] <= '0;
                r_h_cov   <= '0;
                r_h_total <= '0;
                r_src_col <= '0;
                r_dst_col <= '0;
                if (32'(r_src_row) + 32'd1 >= 32'(r_sh) ||
                    32'(r_dst_row) + 32'(r_vclose) >= 32'(r_dh)) begin
                    r_src_row <= '0;
                    r_dst_row <= '0;
                    r_v_cov   <= '0;
                    r_v_total <= '0;
                end else begin
                    r_src_row <= r_src_row + 1'b1;
                    r_dst_row <= r_dst_row + RW'(r_vclose);
                end
            end else begin
                r_src_col <= r_src_col + 1'b1;
                if (r_hclose) begin
                    if (r_hover) begin
                        r_h_cov   <= r_hov2;
                        r_h_total <= r_qh2;
                        for (int c = 0; c < 4; c++)
                            r_span[c] <= SPAN_W'(23'(r_ch[c]) * 23'(r_qh2));
                    end else begin
                        r_h_cov   <= '0;
                        r_h_total <= '0;
                        for (int c = 0; c < 4; c++) r_span[c] <= '0;
                    end
                    if (32'(r_dst_col) + 32'd1 >= 32'(r_dw)) r_dst_col <= '0;
                    else r_dst_col <= r_dst_col + 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_WB && !line_step && wb_go && r_hclose && r_vclose) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WB && !line_step && wb_go && r_hclose && r_vclose) begin
            for (int c = 0; c < 4; c++) r_o_ch[c] <= o_rnd[c][LW-1:VSH];
            r_o_row_end   <= 32'(r_dst_col) + 32'd1 == 32'(r_dw);
            r_o_frame_end <= 32'(r_dst_col) + 32'd1 == 32'(r_dw) &&
                             32'(r_dst_row) + 32'd1 == 32'(r_dh);
        end
    end

    assign o_valid     = r_o_valid;
    assign o_red       = r_o_ch[0];
    assign o_green     = r_o_ch[1];
    assign o_blue      = r_o_ch[2];
    assign o_alpha     = r_o_ch[3];
    assign o_row_end   = r_o_row_end;
    assign o_frame_end = r_o_frame_end;

endmodule
`default_nettype wire
